>>> sv/odometry_to_vehicle_state_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the odometry to vehicle state unit.
// ---------------------------------------------------------------------------
`ifndef ODOMETRY_TO_VEHICLE_STATE_UNIT_ASSERT_SVH
`define ODOMETRY_TO_VEHICLE_STATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ovs_pkg.sv
// ---------------------------------------------------------------------------
// ovs_pkg
// Shared widths, constants and rounding helpers of the vehicle state unit.
// ---------------------------------------------------------------------------
package ovs_pkg;

  // Width of the CORDIC vector datapath and of its angle accumulator (Q.24).
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 28;
  localparam int unsigned TAB_LEN = 24;

  typedef logic signed [CW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [ZW-11:0] angr_t;

  localparam ang_t PI_Q24 = ZW'(52707179);
  localparam ang_t HALF_PI_Q24 = ZW'(26353589);
  localparam int TWO_PI_Q13 = 51472;
  localparam int STEER_MAX = 12868;
  localparam int CURV_POS_MAX = 524287;
  localparam int CURV_NEG_MAG = 524288;

  // Elementary arctangents atan(2^-i) in Q.24.
  localparam ang_t ATAN_Q24 [TAB_LEN] = '{
    ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331),
    ZW'(1047214), ZW'(524117), ZW'(262123), ZW'(131069),
    ZW'(65536), ZW'(32768), ZW'(16384), ZW'(8192),
    ZW'(4096), ZW'(2048), ZW'(1024), ZW'(512),
    ZW'(256), ZW'(128), ZW'(64), ZW'(32),
    ZW'(16), ZW'(8), ZW'(4), ZW'(2)
  };

  // Round a Q.24 angle to Q.13, half up, by a floor shift.
  function automatic angr_t round_q13(ang_t z);
    logic signed [ZW:0] s;
    s = $signed({z[ZW-1], z}) + $signed((ZW+1)'(1024));
    return s[ZW:11];
  endfunction

  // Round and wrap an angle into [0, 2*pi) as unsigned Q3.13.
  function automatic logic [15:0] wrap_q13(ang_t z);
    angr_t r;
    angr_t w;
    r = round_q13(z);
    if (r < 0) begin
      w = r + $signed((ZW-10)'(TWO_PI_Q13));
    end else if (r >= $signed((ZW-10)'(TWO_PI_Q13))) begin
      w = r - $signed((ZW-10)'(TWO_PI_Q13));
    end else begin
      w = r;
    end
    return w[15:0];
  endfunction

endpackage

>>> sv/ovs_delay.sv
// ---------------------------------------------------------------------------
// ovs_delay
// Shift line that keeps side data level with the arithmetic chains.
// ---------------------------------------------------------------------------
module ovs_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [D];

  // Advance the whole line whenever the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int k = 1; k < int'(D); k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[D-1];

endmodule

>>> sv/ovs_sqrt_cell.sv
// ---------------------------------------------------------------------------
// ovs_sqrt_cell
// One digit step of a pipelined integer square root (one root bit a cell).
// ---------------------------------------------------------------------------
module ovs_sqrt_cell #(
  parameter int unsigned N = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*N-1:0] rad_i,
  input  logic [N:0]     rem_i,
  input  logic [N-1:0]   root_i,
  output logic [2*N-1:0] rad_o,
  output logic [N:0]     rem_o,
  output logic [N-1:0]   root_o
);

  logic [N+1:0]   rem_t;
  logic [N+1:0]   trial;
  logic           take;
  logic [2*N-1:0] rad_d, rad_q;
  logic [N:0]     rem_d, rem_q;
  logic [N-1:0]   root_d, root_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_t  = {rem_i[N-1:0], rad_i[2*N-1 -: 2]};
    trial  = {root_i, 2'b01};
    take   = (rem_t >= trial);
    rem_d  = take ? (N+1)'(rem_t - trial) : (N+1)'(rem_t);
    root_d = {root_i[N-2:0], take};
    rad_d  = rad_i << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> sv/ovs_div_cell.sv
// ---------------------------------------------------------------------------
// ovs_div_cell
// One restoring step of a pipelined unsigned divider (one quotient bit).
// ---------------------------------------------------------------------------
module ovs_div_cell #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] quo_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] quo_o
);

  logic [DW:0]   rem_t;
  logic          take;
  logic [NW-1:0] num_q, quo_q, quo_d;
  logic [DW-1:0] den_q, rem_q, rem_d;

  // Shift in the next numerator bit and subtract when the divisor fits.
  always_comb begin
    rem_t = {rem_i, num_i[NW-1]};
    take  = (rem_t >= {1'b0, den_i});
    rem_d = take ? DW'(rem_t - {1'b0, den_i}) : DW'(rem_t);
    quo_d = {quo_i[NW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_i << 1;
      den_q <= den_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

>>> sv/ovs_cordic_cell.sv
// ---------------------------------------------------------------------------
// ovs_cordic_cell
// One vectoring micro-rotation of the arctangent chain.
// ---------------------------------------------------------------------------
module ovs_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  ovs_pkg::vec_t  x_i,
  input  ovs_pkg::vec_t  y_i,
  input  ovs_pkg::ang_t  z_i,
  input  logic           zero_i,
  output ovs_pkg::vec_t  x_o,
  output ovs_pkg::vec_t  y_o,
  output ovs_pkg::ang_t  z_o,
  output logic           zero_o
);
  import ovs_pkg::*;

  vec_t x_d, y_d, x_q, y_q;
  ang_t z_d, z_q;
  logic zero_q;

  // Rotate towards the x axis and account for the angle turned.
  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + ATAN_Q24[IDX];
    end else begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - ATAN_Q24[IDX];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;

endmodule

>>> sv/ovs_cordic.sv
// ---------------------------------------------------------------------------
// ovs_cordic
// Pipelined atan2: a half-plane fold stage followed by a row of rotation cells.
// ---------------------------------------------------------------------------
module ovs_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  ovs_pkg::vec_t x_i,
  input  ovs_pkg::vec_t y_i,
  output ovs_pkg::ang_t z_o
);
  import ovs_pkg::*;

  vec_t x_s [STAGES+1];
  vec_t y_s [STAGES+1];
  ang_t z_s [STAGES+1];
  logic zero_s [STAGES+1];

  // Fold the left half plane onto the right one, starting at +pi or -pi.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_s[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_s[0] <= -x_i;
        y_s[0] <= -y_i;
        z_s[0] <= (y_i >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        x_s[0] <= x_i;
        y_s[0] <= y_i;
        z_s[0] <= '0;
      end
    end
  end

  // Row of micro-rotation cells.
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    ovs_cordic_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .zero_i (zero_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .zero_o (zero_s[i+1])
    );
  end

  // A zero vector has angle zero.
  assign z_o = zero_s[STAGES] ? '0 : z_s[STAGES];

endmodule

>>> sv/odometry_to_vehicle_state_unit.sv
// ---------------------------------------------------------------------------
// odometry_to_vehicle_state_unit
// Turns odometry words into roll, pitch, yaw, speed, curvature and steer.
// ---------------------------------------------------------------------------
// The unit takes one odometry word per clock cycle while the output is not
// stalled and returns one state word for each, in order. The steering path
// is the longest: a 16-cell square root for speed, a 25-cell divider for
// curvature, a gain multiplier and a CORDIC arctangent chain of CORDIC_STAGES
// cells; the other results are delayed to meet it. A stall at the output
// holds the whole pipeline. The steer gain register may be written only
// while the unit is empty.
`include "odometry_to_vehicle_state_unit_assert.svh"

module odometry_to_vehicle_state_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               steer_gain_we_i,
  input  logic [15:0]        steer_gain_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         vehicle_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] lin_vel_x_i,
  input  logic signed [15:0] lin_vel_y_i,
  input  logic signed [15:0] ang_vel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_index_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic [15:0]        roll_o,
  output logic [15:0]        pitch_o,
  output logic [15:0]        yaw_o,
  output logic [15:0]        speed_o,
  output logic signed [19:0] curvature_o,
  output logic signed [14:0] steer_o
);
  import ovs_pkg::*;

  localparam int unsigned VLEN = CORDIC_STAGES + 49;
  localparam int unsigned QW = 35;
  localparam int unsigned SN = 16;
  localparam int unsigned PN = 29;
  localparam int unsigned NW = 25;
  localparam int unsigned DW = 17;

  logic            step;
  logic [VLEN-1:0] valid_q;
  logic [15:0]     gain_q;

  // Steer gain register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd3277;
    end else if (steer_gain_we_i) begin
      gain_q <= steer_gain_i;
    end
  end

  // The pipeline moves unless a finished word waits at the output.
  assign step       = !valid_q[VLEN-1] || out_ready_i;
  assign in_ready_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (step) begin
      valid_q <= {valid_q[VLEN-2:0], in_valid_i};
    end
  end

  // Stage 1: quaternion and velocity products.
  logic signed [31:0] qx_e, qy_e, qz_e, qw_e, vx_e, vy_e;
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q, p_zx_q;
  logic signed [31:0] p_wz_q, p_xy_q, p_zz_q, p_vx_q, p_vy_q;

  assign qx_e = 32'(quat_x_i);
  assign qy_e = 32'(quat_y_i);
  assign qz_e = 32'(quat_z_i);
  assign qw_e = 32'(quat_w_i);
  assign vx_e = 32'(lin_vel_x_i);
  assign vy_e = 32'(lin_vel_y_i);

  always_ff @(posedge clk_i) begin
    if (step) begin
      p_wx_q <= qw_e * qx_e;
      p_yz_q <= qy_e * qz_e;
      p_xx_q <= qx_e * qx_e;
      p_yy_q <= qy_e * qy_e;
      p_wy_q <= qw_e * qy_e;
      p_zx_q <= qz_e * qx_e;
      p_wz_q <= qw_e * qz_e;
      p_xy_q <= qx_e * qy_e;
      p_zz_q <= qz_e * qz_e;
      p_vx_q <= vx_e * vx_e;
      p_vy_q <= vy_e * vy_e;
    end
  end

  // Stage 2: Euler terms in Q.28 and squared speed.
  localparam logic signed [QW-1:0] ONE_Q28 = QW'(1) <<< 28;
  logic signed [QW-1:0] sinr_q, cosr_q, sinp_q, siny_q, cosy_q;
  logic [31:0]          sq_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      sinr_q <= (QW'(p_wx_q) + QW'(p_yz_q)) <<< 1;
      cosr_q <= ONE_Q28 - ((QW'(p_xx_q) + QW'(p_yy_q)) <<< 1);
      sinp_q <= (QW'(p_wy_q) - QW'(p_zx_q)) <<< 1;
      siny_q <= (QW'(p_wz_q) + QW'(p_xy_q)) <<< 1;
      cosy_q <= ONE_Q28 - ((QW'(p_yy_q) + QW'(p_zz_q)) <<< 1);
      sq_q   <= 32'(p_vx_q) + 32'(p_vy_q);
    end
  end

  // Roll and yaw arctangents, then wrap.
  ang_t        roll_z, yaw_z;
  logic [15:0] roll_w_q, yaw_w_q, roll_al, yaw_al;

  ovs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk_i (clk_i), .en_i (step),
    .x_i (CW'(cosr_q)), .y_i (CW'(sinr_q)), .z_o (roll_z)
  );

  ovs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk_i (clk_i), .en_i (step),
    .x_i (CW'(cosy_q)), .y_i (CW'(siny_q)), .z_o (yaw_z)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      roll_w_q <= wrap_q13(roll_z);
      yaw_w_q  <= wrap_q13(yaw_z);
    end
  end

  ovs_delay #(.W(32), .D(44)) u_dly_ry (
    .clk_i (clk_i), .en_i (step),
    .d_i ({roll_w_q, yaw_w_q}), .q_o ({roll_al, yaw_al})
  );

  // Pitch: range check and square of sin(pitch).
  logic signed [QW-1:0] sinp_abs;
  logic [27:0]          sinp_mag;
  logic [55:0]          s2_q;
  logic [1:0]           pflag_q, pflag_al;
  logic [2*PN-1:0]      prad_q;

  assign sinp_abs = (sinp_q < 0) ? -sinp_q : sinp_q;
  assign sinp_mag = sinp_abs[27:0];

  always_ff @(posedge clk_i) begin
    if (step) begin
      s2_q       <= 56'(sinp_mag) * 56'(sinp_mag);
      pflag_q[1] <= (sinp_q >= ONE_Q28) || (sinp_q <= -ONE_Q28);
      pflag_q[0] <= (sinp_q < 0);
      prad_q     <= (2*PN)'(57'(1) << 56) - (2*PN)'(s2_q);
    end
  end

  // Pitch: square root of cos squared, one bit a cell.
  logic [2*PN-1:0] prad_s [PN+1];
  logic [PN:0]     prem_s [PN+1];
  logic [PN-1:0]   proot_s [PN+1];

  assign prad_s[0]  = prad_q;
  assign prem_s[0]  = '0;
  assign proot_s[0] = '0;

  for (genvar i = 0; i < PN; i++) begin : g_psqrt
    ovs_sqrt_cell #(.N(PN)) u_cell (
      .clk_i (clk_i), .en_i (step),
      .rad_i (prad_s[i]), .rem_i (prem_s[i]), .root_i (proot_s[i]),
      .rad_o (prad_s[i+1]), .rem_o (prem_s[i+1]), .root_o (proot_s[i+1])
    );
  end

  logic [PN-1:0] sinp_al;

  ovs_delay #(.W(PN), .D(PN + 2)) u_dly_sinp (
    .clk_i (clk_i), .en_i (step), .d_i (sinp_q[PN-1:0]), .q_o (sinp_al)
  );

  ovs_delay #(.W(2), .D(CORDIC_STAGES + 31)) u_dly_pflag (
    .clk_i (clk_i), .en_i (step), .d_i (pflag_q), .q_o (pflag_al)
  );

  // Pitch arctangent, replaced by +-pi/2 when out of range.
  ang_t        pitch_z, pitch_sel;
  logic [15:0] pitch_w_q, pitch_al;

  ovs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk_i (clk_i), .en_i (step),
    .x_i (CW'({1'b0, proot_s[PN]})), .y_i (CW'($signed(sinp_al))), .z_o (pitch_z)
  );

  always_comb begin
    if (pflag_al[1]) begin
      pitch_sel = pflag_al[0] ? -HALF_PI_Q24 : HALF_PI_Q24;
    end else begin
      pitch_sel = pitch_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pitch_w_q <= wrap_q13(pitch_sel);
    end
  end

  ovs_delay #(.W(16), .D(13)) u_dly_pitch (
    .clk_i (clk_i), .en_i (step), .d_i (pitch_w_q), .q_o (pitch_al)
  );

  // Speed: square root of the squared speed.
  logic [2*SN-1:0] srad_s [SN+1];
  logic [SN:0]     srem_s [SN+1];
  logic [SN-1:0]   sroot_s [SN+1];

  assign srad_s[0]  = sq_q;
  assign srem_s[0]  = '0;
  assign sroot_s[0] = '0;

  for (genvar i = 0; i < SN; i++) begin : g_ssqrt
    ovs_sqrt_cell #(.N(SN)) u_cell (
      .clk_i (clk_i), .en_i (step),
      .rad_i (srad_s[i]), .rem_i (srem_s[i]), .root_i (sroot_s[i]),
      .rad_o (srad_s[i+1]), .rem_o (srem_s[i+1]), .root_o (sroot_s[i+1])
    );
  end

  // Round the speed to nearest and set up the curvature division.
  logic signed [15:0] wz_div, wz_sat;
  logic signed [16:0] wz_ext;
  logic [16:0]        wz_abs;
  logic [15:0]        spd_d, spd_q, spd_al;
  logic [NW-1:0]      num_q;
  logic [DW-1:0]      den_q;
  logic               szero_q, szero_al;

  ovs_delay #(.W(16), .D(SN + 2)) u_dly_wz_div (
    .clk_i (clk_i), .en_i (step), .d_i (ang_vel_z_i), .q_o (wz_div)
  );

  assign spd_d  = sroot_s[SN] + 16'(srem_s[SN] > {1'b0, sroot_s[SN]});
  assign wz_ext = 17'(wz_div);
  assign wz_abs = (wz_ext < 0) ? 17'(-wz_ext) : 17'(wz_ext);

  always_ff @(posedge clk_i) begin
    if (step) begin
      spd_q   <= spd_d;
      szero_q <= (spd_d == '0);
      num_q   <= NW'({wz_abs[15:0], 9'd0}) + NW'(spd_d);
      den_q   <= {spd_d, 1'b0};
    end
  end

  ovs_delay #(.W(16), .D(CORDIC_STAGES + 29)) u_dly_spd (
    .clk_i (clk_i), .en_i (step), .d_i (spd_q), .q_o (spd_al)
  );

  ovs_delay #(.W(1), .D(NW)) u_dly_szero (
    .clk_i (clk_i), .en_i (step), .d_i (szero_q), .q_o (szero_al)
  );

  ovs_delay #(.W(16), .D(SN + NW + 3)) u_dly_wz_sat (
    .clk_i (clk_i), .en_i (step), .d_i (ang_vel_z_i), .q_o (wz_sat)
  );

  // Curvature division, one quotient bit a cell.
  logic [NW-1:0] num_s [NW+1];
  logic [DW-1:0] den_s [NW+1];
  logic [DW-1:0] drem_s [NW+1];
  logic [NW-1:0] quo_s [NW+1];

  assign num_s[0]  = num_q;
  assign den_s[0]  = den_q;
  assign drem_s[0] = '0;
  assign quo_s[0]  = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    ovs_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk_i (clk_i), .en_i (step),
      .num_i (num_s[i]), .den_i (den_s[i]), .rem_i (drem_s[i]), .quo_i (quo_s[i]),
      .num_o (num_s[i+1]), .den_o (den_s[i+1]), .rem_o (drem_s[i+1]),
      .quo_o (quo_s[i+1])
    );
  end

  // Saturate the quotient and apply the sign of the yaw rate; at standstill the yaw rate itself is taken.
  logic signed [19:0] curv_d, curv_q, curv_al;
  logic [20:0]        qs;

  always_comb begin
    qs = '0;
    if (szero_al) begin
      curv_d = 20'(wz_sat);
    end else if (wz_sat < 0) begin
      qs     = (quo_s[NW] > NW'(CURV_NEG_MAG)) ? 21'(CURV_NEG_MAG) : 21'(quo_s[NW]);
      curv_d = 20'(21'd0 - qs);
    end else begin
      qs     = (quo_s[NW] > NW'(CURV_POS_MAX)) ? 21'(CURV_POS_MAX) : 21'(quo_s[NW]);
      curv_d = 20'(qs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      curv_q <= curv_d;
    end
  end

  ovs_delay #(.W(20), .D(CORDIC_STAGES + 3)) u_dly_curv (
    .clk_i (clk_i), .en_i (step), .d_i (curv_q), .q_o (curv_al)
  );

  // Steering: gain product, arctangent against one, round and clamp.
  logic signed [36:0] gp_q;
  ang_t               steer_z;
  angr_t              steer_r;
  logic signed [14:0] steer_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      gp_q <= 37'(curv_q) * $signed({21'd0, gain_q});
    end
  end

  ovs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_steer (
    .clk_i (clk_i), .en_i (step),
    .x_i (CW'(1) <<< 28), .y_i (CW'(gp_q)), .z_o (steer_z)
  );

  assign steer_r = round_q13(steer_z);

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (steer_r > $signed((ZW-10)'(STEER_MAX))) begin
        steer_q <= 15'(STEER_MAX);
      end else if (steer_r < -$signed((ZW-10)'(STEER_MAX))) begin
        steer_q <= -15'(STEER_MAX);
      end else begin
        steer_q <= steer_r[14:0];
      end
    end
  end

  // Index and position ride alongside the arithmetic.
  logic [71:0] pass_al;

  ovs_delay #(.W(72), .D(CORDIC_STAGES + 48)) u_dly_pass (
    .clk_i (clk_i), .en_i (step),
    .d_i ({vehicle_index_i, pos_x_i, pos_y_i}), .q_o (pass_al)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_index_o <= pass_al[71:64];
      out_pos_x_o <= pass_al[63:32];
      out_pos_y_o <= pass_al[31:0];
      roll_o      <= roll_al;
      pitch_o     <= pitch_al;
      yaw_o       <= yaw_al;
      speed_o     <= spd_al;
      curvature_o <= curv_al;
      steer_o     <= steer_q;
    end
  end

  assign out_valid_o = valid_q[VLEN-1];

  // Checks on the datapath results and on the stall behaviour.
  `OVS_ASSERT_NOW(a_angle_range, out_valid_o,
    (roll_o < 16'(TWO_PI_Q13)) && (pitch_o < 16'(TWO_PI_Q13)) && (yaw_o < 16'(TWO_PI_Q13)),
    "angle word outside [0, 2*pi)")
  `OVS_ASSERT_NOW(a_steer_range, out_valid_o,
    (steer_o <= 15'(STEER_MAX)) && (steer_o >= -15'(STEER_MAX)),
    "steer word outside its clamp")
  `OVS_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, $stable(valid_q),
    "pipeline moved while the output was stalled")

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the odometry to vehicle state unit. A table of
// directed odometry words runs first, then random words under several steer
// gain settings. Each state word is compared field by field with a
// bit-accurate model of the CORDIC, square-root and divider arithmetic.
// Both handshakes idle at random.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 49;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NONE = 32'h7fffffff;
  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint PI_Q24 = 52707179;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint TWO_PI_Q13 = 51472;
  localparam longint STEER_LIM = 12868;

  localparam longint ATAN_TAB [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
  } odo_t;

  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        roll;
    logic [15:0]        pitch;
    logic [15:0]        yaw;
    logic [15:0]        speed;
    logic signed [19:0] curv;
    logic signed [14:0] steer;
  } state_t;

  // One directed row: the word, plus values typed in where they are obvious.
  typedef struct {
    odo_t s;
    int   pitch;
    int   yaw;
    int   speed;
    int   curv;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               steer_gain_we_i;
  logic [15:0]        steer_gain_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         vehicle_index_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [15:0] quat_x_i;
  logic signed [15:0] quat_y_i;
  logic signed [15:0] quat_z_i;
  logic signed [15:0] quat_w_i;
  logic signed [15:0] lin_vel_x_i;
  logic signed [15:0] lin_vel_y_i;
  logic signed [15:0] ang_vel_z_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         out_index_o;
  logic signed [31:0] out_pos_x_o;
  logic signed [31:0] out_pos_y_o;
  logic [15:0]        roll_o;
  logic [15:0]        pitch_o;
  logic [15:0]        yaw_o;
  logic [15:0]        speed_o;
  logic signed [19:0] curvature_o;
  logic signed [14:0] steer_o;

  state_t pending_states[$];
  logic [15:0] gain_shadow;
  int errors = 0;
  int cycles = 0;
  bit hold_req = 0;
  bit quiet = 0;

  odometry_to_vehicle_state_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .steer_gain_we_i(steer_gain_we_i), .steer_gain_i(steer_gain_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .vehicle_index_i(vehicle_index_i), .pos_x_i(pos_x_i), .pos_y_i(pos_y_i),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i), .quat_z_i(quat_z_i),
    .quat_w_i(quat_w_i), .lin_vel_x_i(lin_vel_x_i), .lin_vel_y_i(lin_vel_y_i),
    .ang_vel_z_i(ang_vel_z_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_index_o(out_index_o), .out_pos_x_o(out_pos_x_o),
    .out_pos_y_o(out_pos_y_o), .roll_o(roll_o), .pitch_o(pitch_o),
    .yaw_o(yaw_o), .speed_o(speed_o), .curvature_o(curvature_o),
    .steer_o(steer_o)
  );

  always #4 clk_i = ~clk_i;

  // Integer square root, floor.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // CORDIC vectoring arctangent, angle in Q.24.
  function automatic longint cordic_atan2(longint y, longint x);
    longint z;
    longint nx;
    longint ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q24 : -PI_Q24;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // Round a Q.24 angle to Q.13 and wrap it into [0, 2*pi).
  function automatic logic [15:0] wrapped_angle(longint z);
    longint r;
    r = (z + 1024) >>> 11;
    if (r < 0) r = r + TWO_PI_Q13;
    if (r >= TWO_PI_Q13) r = r - TWO_PI_Q13;
    return r[15:0];
  endfunction

  // Full vehicle state for one odometry word under the given steer gain.
  function automatic state_t vehicle_state_of(odo_t s, logic [15:0] gain);
    state_t e;
    longint qx, qy, qz, qw, vx, vy, wz;
    longint sinr, cosr, sinp, siny, cosy, pz, curv, st;
    longint unsigned sq, spd, mag, q, c;
    qx = s.qx; qy = s.qy; qz = s.qz; qw = s.qw;
    vx = s.vx; vy = s.vy; wz = s.wz;
    sinr = 2 * (qw * qx + qy * qz);
    cosr = ONE_Q28 - 2 * (qx * qx + qy * qy);
    sinp = 2 * (qw * qy - qz * qx);
    siny = 2 * (qw * qz + qx * qy);
    cosy = ONE_Q28 - 2 * (qy * qy + qz * qz);
    if (sinp >= ONE_Q28) begin
      pz = HALF_PI_Q24;
    end else if (sinp <= -ONE_Q28) begin
      pz = -HALF_PI_Q24;
    end else begin
      c = floor_sqrt((64'd1 << 56) - longint'(sinp * sinp));
      pz = cordic_atan2(sinp, longint'(c));
    end
    sq = vx * vx + vy * vy;
    spd = floor_sqrt(sq);
    if (sq - spd * spd > spd) spd = spd + 1;
    // Standing still: the yaw rate itself is taken as curvature.
    if (spd == 0) begin
      curv = wz;
    end else begin
      mag = (wz < 0 ? -wz : wz) << 8;
      q = (2 * mag + spd) / (2 * spd);
      if (wz < 0) begin
        if (q > 524288) q = 524288;
        curv = -longint'(q);
      end else begin
        if (q > 524287) q = 524287;
        curv = q;
      end
    end
    st = (cordic_atan2(curv * longint'(gain), ONE_Q28) + 1024) >>> 11;
    if (st > STEER_LIM) st = STEER_LIM;
    if (st < -STEER_LIM) st = -STEER_LIM;
    e.index = s.index;
    e.pos_x = s.pos_x;
    e.pos_y = s.pos_y;
    e.roll = wrapped_angle(cordic_atan2(sinr, cosr));
    e.pitch = wrapped_angle(pz);
    e.yaw = wrapped_angle(cordic_atan2(siny, cosy));
    e.speed = spd[15:0];
    e.curv = curv[19:0];
    e.steer = st[14:0];
    return e;
  endfunction

  // Random odometry word: full-range noise, orientation components within +-1,
  // standstill and creeping speeds that push curvature to its limits.
  function automatic odo_t random_sample();
    odo_t s;
    int mode;
    mode = $urandom_range(0, 7);
    s.index = 8'($urandom);
    s.pos_x = $urandom;
    s.pos_y = $urandom;
    if (mode < 2) begin
      s.qx = 16'($urandom); s.qy = 16'($urandom);
      s.qz = 16'($urandom); s.qw = 16'($urandom);
    end else begin
      s.qx = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      s.qy = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      s.qz = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      s.qw = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    end
    s.vx = 16'($urandom);
    s.vy = 16'($urandom);
    s.wz = 16'($urandom);
    if (mode == 6) begin
      s.vx = 0;
      s.vy = 0;
    end else if (mode == 7) begin
      s.vx = $signed(16'($urandom_range(0, 8))) - 16'sd4;
      s.vy = $signed(16'($urandom_range(0, 8))) - 16'sd4;
    end
    return s;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word, hold it until taken, record its expected state.
  task automatic offer_sample(input odo_t s, input int xp, input int xy,
                              input int xs, input int xc, input int gap);
    state_t e;
    in_valid_i <= 1'b1;
    vehicle_index_i <= s.index;
    pos_x_i <= s.pos_x;
    pos_y_i <= s.pos_y;
    quat_x_i <= s.qx;
    quat_y_i <= s.qy;
    quat_z_i <= s.qz;
    quat_w_i <= s.qw;
    lin_vel_x_i <= s.vx;
    lin_vel_y_i <= s.vy;
    ang_vel_z_i <= s.wz;
    do @(posedge clk_i); while (!in_ready_o);
    e = vehicle_state_of(s, gain_shadow);
    if (xp != NONE) e.pitch = 16'(xp);
    if (xy != NONE) e.yaw = 16'(xy);
    if (xs != NONE) e.speed = 16'(xs);
    if (xc != NONE) e.curv = 20'(xc);
    pending_states.push_back(e);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_states.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [15:0] g);
    steer_gain_we_i <= 1'b1;
    steer_gain_i <= g;
    @(posedge clk_i);
    steer_gain_we_i <= 1'b0;
    gain_shadow = g;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) offer_sample(random_sample(), NONE, NONE, NONE, NONE,
                                             sender_gap());
  endtask

  function automatic row_t mk(input odo_t s, input int p, input int y,
                              input int sp, input int c);
    row_t r;
    r.s = s; r.pitch = p; r.yaw = y; r.speed = sp; r.curv = c;
    return r;
  endfunction

  // Receiver: random stalls, rare long ones, and a long hold-off on request.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 199);
        if (quiet || r >= 30) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left = (r < 3) ? $urandom_range(20, 60) : $urandom_range(0, 3);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // Compare each state word taken with the oldest expected one.
  always @(posedge clk_i) begin
    state_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_states.size() == 0) begin
        $error("state word with nothing expected");
        errors++;
      end else begin
        e = pending_states.pop_front();
        if (out_index_o !== e.index) begin
          $error("out_index exp %0d got %0d", e.index, out_index_o); errors++;
        end
        if (out_pos_x_o !== e.pos_x) begin
          $error("out_pos_x exp %0d got %0d", e.pos_x, out_pos_x_o); errors++;
        end
        if (out_pos_y_o !== e.pos_y) begin
          $error("out_pos_y exp %0d got %0d", e.pos_y, out_pos_y_o); errors++;
        end
        if (roll_o !== e.roll) begin
          $error("roll exp %0d got %0d", e.roll, roll_o); errors++;
        end
        if (pitch_o !== e.pitch) begin
          $error("pitch exp %0d got %0d", e.pitch, pitch_o); errors++;
        end
        if (yaw_o !== e.yaw) begin
          $error("yaw exp %0d got %0d", e.yaw, yaw_o); errors++;
        end
        if (speed_o !== e.speed) begin
          $error("speed exp %0d got %0d", e.speed, speed_o); errors++;
        end
        if (curvature_o !== e.curv) begin
          $error("curvature exp %0d got %0d", e.curv, curvature_o); errors++;
        end
        if (steer_o !== e.steer) begin
          $error("steer exp %0d got %0d", e.steer, steer_o); errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    odo_t s;
    rst_ni = 1'b0;
    steer_gain_we_i = 1'b0;
    steer_gain_i = '0;
    in_valid_i = 1'b0;
    vehicle_index_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    quat_x_i = '0;
    quat_y_i = '0;
    quat_z_i = '0;
    quat_w_i = '0;
    lin_vel_x_i = '0;
    lin_vel_y_i = '0;
    ang_vel_z_i = '0;
    gain_shadow = 16'd3277;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: identity, standstill, pitch clamps, zero vector,
    // curvature saturation, field extremes and the negative-x branch.
    s = '{8'd1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    rows.push_back(mk(s, NONE, NONE, 0, 0));
    s.wz = 16'sd32767;
    rows.push_back(mk(s, NONE, NONE, 0, 32767));
    s.wz = -16'sd32768;
    rows.push_back(mk(s, NONE, NONE, 0, -32768));
    s = '{8'd4, 32'sd65536, -32'sd65536, 16'sd0, 16'sd11586, 16'sd0, 16'sd11586,
          16'sd256, 16'sd0, 16'sd100};
    rows.push_back(mk(s, 12868, NONE, 256, NONE));
    s.qy = -16'sd11586;
    rows.push_back(mk(s, 38604, NONE, 256, NONE));
    s = '{8'd6, 32'sd1, 32'sd2, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    rows.push_back(mk(s, NONE, 0, 0, 0));
    s = '{8'd7, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd1, 16'sd0,
          16'sd32767};
    rows.push_back(mk(s, NONE, NONE, 1, 524287));
    s.vx = 16'sd0; s.vy = -16'sd1; s.wz = -16'sd32768;
    rows.push_back(mk(s, NONE, NONE, 1, -524288));
    s = '{8'd255, 32'sh7fffffff, 32'sh7fffffff, 16'sd32767, 16'sd32767, 16'sd32767,
          16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
    rows.push_back(mk(s, NONE, NONE, NONE, NONE));
    s = '{8'd0, 32'sh80000000, 32'sh80000000, -16'sd32768, -16'sd32768, -16'sd32768,
          -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    rows.push_back(mk(s, NONE, NONE, 46341, NONE));
    s = '{8'd11, 32'sd5, -32'sd5, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd512, -16'sd300,
          16'sd4096};
    rows.push_back(mk(s, NONE, NONE, NONE, NONE));
    s.qz = -16'sd100; s.qy = 16'sd50;
    rows.push_back(mk(s, NONE, NONE, NONE, NONE));
    s = '{8'd13, 32'sd0, 32'sd0, 16'sd20000, -16'sd9000, 16'sd30000, -16'sd25000,
          -16'sd1, 16'sd0, -16'sd1};
    rows.push_back(mk(s, NONE, NONE, 1, NONE));
    foreach (rows[i])
      offer_sample(rows[i].s, rows[i].pitch, rows[i].yaw, rows[i].speed, rows[i].curv,
                   sender_gap());
    random_phase(100);
    drain();

    // No steering gain at all.
    write_gain(16'd0);
    random_phase(100);

    // The sender waits for every expected word before going on.
    drain();
    random_phase(30);
    drain();

    // Full gain, with the receiver holding off long enough to fill the unit.
    write_gain(16'hffff);
    quiet = 1;
    hold_req = 1;
    random_phase(120);
    quiet = 0;
    drain();

    write_gain(16'($urandom));
    random_phase(100);
    drain();

    write_gain(16'd3277);
    random_phase(90);
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
